// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BIR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BIR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bir_pkg.sv =====
// Shared types and constants of the bilinear image resampler.
// Depends on nothing; used by every module of the block but the image memory.
package bir_pkg;

  // Fixed field widths of the transaction ports
  localparam int PixIdxW = 10;
  localparam int PixW    = 8;
  localparam int CoordW  = 5;

  // Internal widths sized for the largest legal image and grid (256 per side)
  localparam int IdxW   = 16;
  localparam int WgtW   = 9;
  localparam int WProdW = 17;
  localparam int SumW   = PixW + WProdW;

  // Default geometry
  localparam int InWDef  = 28;
  localparam int InHDef  = 28;
  localparam int OutWDef = 32;
  localparam int OutHDef = 32;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } bir_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_MAC,
    ST_ACC,
    ST_DIV
  } bir_state_e;

  // One axis of a neighborhood: offsets of both taps and their weights
  typedef struct packed {
    logic [IdxW-1:0] lo_off;
    logic [IdxW-1:0] hi_off;
    logic [WgtW-1:0] w_lo;
    logic [WgtW-1:0] w_hi;
  } bir_axis_t;

endpackage

// ===== sv/bir_image_mem.sv =====
// Single-port source image memory with a registered read port.
// Depends on nothing from the package; geometry comes in by parameters.
module bir_image_mem #(
  parameter int Depth = 784,
  parameter int AW    = 10,
  parameter int DW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [Depth];
  logic [DW-1:0] rdata_q;

  // Write on request, otherwise read into the output register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bir_axis_lut.sv =====
// Constant table mapping an output coordinate to source taps and weights.
// Depends on bir_pkg for the axis struct and widths.
module bir_axis_lut #(
  parameter int InN    = 28,
  parameter int OutN   = 32,
  parameter int Stride = 1
) (
  input  logic [bir_pkg::CoordW-1:0] pos_i,
  output bir_pkg::bir_axis_t         axis_o
);
  import bir_pkg::*;

  localparam int Entries = 2 ** CoordW;

  bir_axis_t tab [Entries];

  // Build each entry at elaboration: saturate, scale, split, clamp
  for (genvar i = 0; i < Entries; i++) begin : g_entry
    localparam int P  = (i < OutN) ? i : OutN - 1;
    localparam int S  = P * InN;
    localparam int B0 = S / OutN;
    localparam int B  = (B0 > InN - 1) ? InN - 1 : B0;
    localparam int N  = (B + 1 > InN - 1) ? InN - 1 : B + 1;
    localparam int F  = S % OutN;
    assign tab[i].lo_off = IdxW'(B * Stride);
    assign tab[i].hi_off = IdxW'(N * Stride);
    assign tab[i].w_lo   = WgtW'(OutN - F);
    assign tab[i].w_hi   = WgtW'(F);
  end

  assign axis_o = tab[pos_i];

endmodule

// ===== sv/bir_seq.sv =====
// Read sequencer: fetches four taps, accumulates weighted products and
// divides by the grid area with one reciprocal multiply. Depends on bir_pkg.
module bir_seq #(
  parameter int AW   = 10,
  parameter int OutW = 32,
  parameter int OutH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_start_i,
  input  bir_pkg::bir_axis_t       x_i,
  input  bir_pkg::bir_axis_t       y_i,
  input  logic [bir_pkg::PixW-1:0] rdata_i,
  output logic [AW-1:0]            rd_addr_o,
  output logic                     busy_o,
  output logic                     valid_o,
  output logic [bir_pkg::PixW-1:0] pixel_o
);
  import bir_pkg::*;

  // The sum stays below 2^(PixW+DivLog), so a reciprocal with
  // PixW+2*DivLog fraction bits gives the exact truncated quotient
  localparam int Div    = OutW * OutH;
  localparam int DivLog = $clog2(Div);
  localparam int RcpSh  = PixW + 2 * DivLog;
  localparam int RcpW   = PixW + DivLog + 2;
  localparam int ScW    = SumW + RcpW;
  localparam longint unsigned RcpFull =
      ((64'd1 << RcpSh) + 64'(Div) - 64'd1) / 64'(Div);
  localparam logic [RcpW-1:0] RcpMul = RcpW'(RcpFull);

  bir_state_e        state_q, state_d;
  logic              valid_q, valid_d;
  bir_axis_t         x_q, x_d, y_q, y_d;
  logic [WProdW-1:0] w00_q, w00_d, w01_q, w01_d, w10_q, w10_d, w11_q, w11_d;
  logic [SumW-1:0]   prod_q, prod_d, acc_q, acc_d, sum_q, sum_d;
  logic [PixW-1:0]   pix_q, pix_d;

  logic [WProdW-1:0] wsel;
  logic [IdxW-1:0]   addr_full;
  logic [ScW-1:0]    scaled;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    w00_q  <= w00_d;
    w01_q  <= w01_d;
    w10_q  <= w10_d;
    w11_q  <= w11_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    sum_q  <= sum_d;
    pix_q  <= pix_d;
  end

  // Scale the closed sum by the reciprocal of the grid area
  assign scaled = ScW'(sum_q) * ScW'(RcpMul);

  // Next state, tap addresses and datapath updates
  always_comb begin
    state_d   = state_q;
    valid_d   = 1'b0;
    x_d       = x_q;
    y_d       = y_q;
    w00_d     = w00_q;
    w01_d     = w01_q;
    w10_d     = w10_q;
    w11_d     = w11_q;
    prod_d    = prod_q;
    acc_d     = acc_q;
    sum_d     = sum_q;
    pix_d     = pix_q;
    wsel      = w00_q;
    addr_full = y_q.lo_off + x_q.lo_off;

    unique case (state_q)
      ST_IDLE: begin
        // Capture the neighborhood of an accepted read
        if (rd_start_i) begin
          x_d     = x_i;
          y_d     = y_i;
          state_d = ST_RD0;
        end
      end
      ST_RD0: begin
        addr_full = y_q.lo_off + x_q.lo_off;
        w00_d     = WProdW'(x_q.w_lo) * WProdW'(y_q.w_lo);
        w01_d     = WProdW'(x_q.w_hi) * WProdW'(y_q.w_lo);
        w10_d     = WProdW'(x_q.w_lo) * WProdW'(y_q.w_hi);
        w11_d     = WProdW'(x_q.w_hi) * WProdW'(y_q.w_hi);
        state_d   = ST_RD1;
      end
      ST_RD1: begin
        addr_full = y_q.lo_off + x_q.hi_off;
        wsel      = w00_q;
        prod_d    = SumW'(rdata_i) * SumW'(wsel);
        acc_d     = '0;
        state_d   = ST_RD2;
      end
      ST_RD2: begin
        addr_full = y_q.hi_off + x_q.lo_off;
        wsel      = w01_q;
        prod_d    = SumW'(rdata_i) * SumW'(wsel);
        acc_d     = acc_q + prod_q;
        state_d   = ST_RD3;
      end
      ST_RD3: begin
        addr_full = y_q.hi_off + x_q.hi_off;
        wsel      = w10_q;
        prod_d    = SumW'(rdata_i) * SumW'(wsel);
        acc_d     = acc_q + prod_q;
        state_d   = ST_MAC;
      end
      ST_MAC: begin
        wsel    = w11_q;
        prod_d  = SumW'(rdata_i) * SumW'(wsel);
        acc_d   = acc_q + prod_q;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        // Close the sum
        sum_d   = acc_q + prod_q;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // Take the quotient bits and strobe the result
        pix_d   = scaled[RcpSh +: PixW];
        valid_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rd_addr_o = AW'(addr_full);
  assign busy_o    = (state_q != ST_IDLE);
  assign valid_o   = valid_q;
  assign pixel_o   = pix_q;

endmodule

// ===== sv/bilinear_image_resampler.sv =====
// Bilinear image resampler; depends on bir_pkg, bir_axis_lut, bir_image_mem, bir_seq.
// A write leaves busy low. A read holds busy through states RD0 to RD3, which
// fetch four taps from the single-port image memory, MAC and ACC, which
// accumulate, and DIV, which does one reciprocal multiply; valid_o pulses in
// the cycle busy falls, reads are taken only while idle and the result never stalls.
// Reset clears the sequencer and strobe; image contents are kept as written.
module bilinear_image_resampler #(
  parameter int IN_W  = bir_pkg::InWDef,
  parameter int IN_H  = bir_pkg::InHDef,
  parameter int OUT_W = bir_pkg::OutWDef,
  parameter int OUT_H = bir_pkg::OutHDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        operation_i,
  input  logic [bir_pkg::PixIdxW-1:0] pixel_index_i,
  input  logic [bir_pkg::PixW-1:0]    pixel_value_i,
  input  logic [bir_pkg::CoordW-1:0]  out_x_i,
  input  logic [bir_pkg::CoordW-1:0]  out_y_i,
  output logic                        valid_o,
  output logic [bir_pkg::PixW-1:0]    resized_pixel_o
);
  import bir_pkg::*;

  localparam int ImgSize = IN_W * IN_H;
  localparam int AW      = $clog2(ImgSize);

  bir_axis_t       x_axis, y_axis;
  logic            seq_busy;
  logic            rd_start, wr_en;
  logic [AW-1:0]   rd_addr, mem_addr;
  logic [PixW-1:0] rdata;

  // Decode an accepted transaction; drop writes beyond the image
  assign rd_start = start && !seq_busy && (operation_i == OP_READ);
  assign wr_en    = start && !seq_busy && (operation_i == OP_WRITE) &&
                    (32'(pixel_index_i) < 32'(ImgSize));
  assign mem_addr = seq_busy ? rd_addr : AW'(pixel_index_i);

  bir_axis_lut #(
    .InN    (IN_W),
    .OutN   (OUT_W),
    .Stride (1)
  ) u_lut_x (
    .pos_i  (out_x_i),
    .axis_o (x_axis)
  );

  bir_axis_lut #(
    .InN    (IN_H),
    .OutN   (OUT_H),
    .Stride (IN_W)
  ) u_lut_y (
    .pos_i  (out_y_i),
    .axis_o (y_axis)
  );

  bir_image_mem #(
    .Depth (ImgSize),
    .AW    (AW),
    .DW    (PixW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .addr_i  (mem_addr),
    .wdata_i (pixel_value_i),
    .rdata_o (rdata)
  );

  bir_seq #(
    .AW   (AW),
    .OutW (OUT_W),
    .OutH (OUT_H)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_start_i (rd_start),
    .x_i        (x_axis),
    .y_i        (y_axis),
    .rdata_i    (rdata),
    .rd_addr_o  (rd_addr),
    .busy_o     (seq_busy),
    .valid_o    (valid_o),
    .pixel_o    (resized_pixel_o)
  );

  assign busy = seq_busy;

endmodule

// ===== sv/bir_checker.sv =====
// Port-level checker for the bilinear image resampler, bound to the top.
// Depends on bir_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bir_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic operation_i,
  input logic valid_o
);
  import bir_pkg::*;

  // A read transaction occupies the block from the next cycle on
  `BIR_ASSERT_NXT(a_read_busy, clk_i, rst_ni, start && !busy && (operation_i == OP_READ), busy, "read did not raise busy")

  // A write transaction completes in its own cycle
  `BIR_ASSERT_NXT(a_write_idle, clk_i, rst_ni, start && !busy && (operation_i == OP_WRITE), !busy && !valid_o, "write held the block")

  // The result strobe appears exactly as the block frees up
  `BIR_ASSERT_NOW(a_valid_idle, clk_i, rst_ni, valid_o, !busy, "result strobed while busy")
  `BIR_ASSERT_NOW(a_fall_valid, clk_i, rst_ni, $fell(busy), valid_o, "busy dropped without a result")

  // The strobe lasts a single cycle
  `BIR_ASSERT_NXT(a_valid_pulse, clk_i, rst_ni, valid_o, !valid_o, "result strobe held")

endmodule

bind bilinear_image_resampler bir_checker u_bir_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .operation_i (operation_i),
  .valid_o     (valid_o)
);
